// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam logic [7:0]  HDR_FIRST       = 8'h5D;
    localparam logic [7:0]  HDR_SECOND      = 8'h7E;
    localparam logic [7:0]  END_BYTE        = 8'h5E;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd100;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CRC = 2'd1,
        ST_BAD_END = 2'd2,
        ST_BAD_LEN = 2'd3
    } status_t;

    // one frame outcome, front to back
    typedef struct packed {
        status_t    status;
        logic [7:0] length;
        logic       use_ram;
        logic       bank;
    } cmd_t;

    // one result request
    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
        logic       last;
    } res_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/crc_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// crc_frame_receiver_core
// UART frame receiver with CRC-16/MODBUS check; emits payload bytes of good
// frames and one status result for rejected frames.
//
//   channel   direction  handshake          payload
//   input     in         push / full        mode, rx_byte
//   result    out        empty / pop        status, payload_byte,
//                                           payload_length, last
//   config    in         cfg_valid / ready  cfg_data (idle_timeout_ms)
//
// Input items are accepted whenever full is low; full rises only while two
// frame outcomes wait in the command queue.
// Results pass through the registered payload RAM read into a two-entry
// result queue; reads stall while the two together hold two results.
// Payload RAM is double-banked so a new frame fills while the last drains.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module crc_frame_receiver_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_length,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              acc;
    logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
    crcfr_pkg::cmd_t   cmd_in, cmd_head;
    logic              ram_we, ram_re;
    logic [IW:0]       ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    crcfr_pkg::res_t   res;

    assign cfg_ready      = 1'b1;
    assign full           = cmd_full;
    assign acc            = push && !cmd_full;
    assign status         = res.status;
    assign payload_byte   = res.payload_byte;
    assign payload_length = res.payload_length;
    assign last           = res.last;

    crcfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd_out   (cmd_in),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    crcfr_cmd_q u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .full  (cmd_full),
        .empty (cmd_empty),
        .head  (cmd_head)
    );

    crcfr_ram #(
        .WIDTH (8),
        .DEPTH (2 << IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crcfr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

endmodule

// ===== src/crcfr_ram.sv =====
// ----------------------------------------------------------------------------
// crcfr_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== src/crcfr_front.sv =====
// ----------------------------------------------------------------------------
// crcfr_front
// Frame parser: hunts headers, keeps the running CRC, stores payload bytes
// and posts one command per finished or rejected frame; an idle timeout drops a partial frame with none.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crcfr_front #(
    parameter int MAX_PAYLOAD = 32,
    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic              mode,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    output logic              cmd_push,
    output crcfr_pkg::cmd_t   cmd_out,
    output logic              ram_we,
    output logic [IW:0]       ram_waddr,
    output logic [7:0]        ram_wdata
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_WAIT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRCLO = 3'd4,
        PH_CRCHI = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] timeout_reg, timeout_next;
    logic        bank_reg, bank_next;
    logic [15:0] idle_inc;
    logic [15:0] crc_upd;

    assign crc_upd   = crcfr_pkg::crc_feed(crc_reg, rx_byte);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign ram_waddr = {bank_reg, cnt_reg[IW-1:0]};
    assign ram_wdata = rx_byte;

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        rcrc_next    = rcrc_reg;
        idle_next    = idle_reg;
        bank_next    = bank_reg;
        timeout_next = cfg_we ? cfg_data : timeout_reg;
        cmd_push     = 1'b0;
        cmd_out      = '0;
        ram_we       = 1'b0;

        if (acc && mode)
        begin
            idle_next = idle_inc;
            if (idle_inc > timeout_reg)
            begin
                idle_next  = '0;
                phase_next = PH_HUNT;
                crc_next   = crcfr_pkg::CRC_INIT;
                len_next   = '0;
                cnt_next   = '0;
                rcrc_next  = '0;
            end
        end
        else if (acc)
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == crcfr_pkg::HDR_FIRST)
                    begin
                        crc_next   = crcfr_pkg::crc_feed(crcfr_pkg::CRC_INIT, rx_byte);
                        phase_next = PH_WAIT2;
                    end
                end
                PH_WAIT2:
                begin
                    if (rx_byte == crcfr_pkg::HDR_SECOND)
                    begin
                        crc_next   = crc_upd;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    len_next = rx_byte;
                    crc_next = crc_upd;
                    cnt_next = '0;
                    if (rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        cmd_push       = 1'b1;
                        cmd_out.status = crcfr_pkg::ST_BAD_LEN;
                        cmd_out.length = rx_byte;
                        phase_next     = PH_HUNT;
                        crc_next       = crcfr_pkg::CRC_INIT;
                        len_next       = '0;
                        rcrc_next      = '0;
                    end
                    else
                    begin
                        phase_next = (rx_byte == 8'd0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + 8'd1;
                    crc_next = crc_upd;
                    if (cnt_reg + 8'd1 >= len_reg)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    rcrc_next  = {8'h00, rx_byte};
                    phase_next = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    rcrc_next  = {rx_byte, rcrc_reg[7:0]};
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    cmd_push       = 1'b1;
                    cmd_out.length = len_reg;
                    cmd_out.bank   = bank_reg;
                    if (rcrc_reg != crc_reg)
                    begin
                        cmd_out.status = crcfr_pkg::ST_BAD_CRC;
                    end
                    else if (rx_byte != crcfr_pkg::END_BYTE)
                    begin
                        cmd_out.status = crcfr_pkg::ST_BAD_END;
                    end
                    else
                    begin
                        cmd_out.status  = crcfr_pkg::ST_OK;
                        cmd_out.use_ram = (len_reg != 8'd0);
                        if (len_reg != 8'd0)
                        begin
                            bank_next = ~bank_reg;
                        end
                    end
                    phase_next = PH_HUNT;
                    crc_next   = crcfr_pkg::CRC_INIT;
                    len_next   = '0;
                    cnt_next   = '0;
                    rcrc_next  = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    crc_next   = crcfr_pkg::CRC_INIT;
                    len_next   = '0;
                    cnt_next   = '0;
                    rcrc_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= crcfr_pkg::CRC_INIT;
            len_reg     <= '0;
            cnt_reg     <= '0;
            rcrc_reg    <= '0;
            idle_reg    <= '0;
            timeout_reg <= crcfr_pkg::TIMEOUT_DEFAULT;
            bank_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            rcrc_reg    <= rcrc_next;
            idle_reg    <= idle_next;
            timeout_reg <= timeout_next;
            bank_reg    <= bank_next;
        end
    end

    `CHK_IMPLY(a_data_in_range, clk, rst_n, phase_reg == PH_DATA, cnt_reg < len_reg, "byte count past frame length")
    `CHK_IMPLY(a_len_fits, clk, rst_n, phase_reg == PH_DATA, len_reg <= 8'(MAX_PAYLOAD), "stored frame longer than buffer")

endmodule

// ===== src/crcfr_cmd_q.sv =====
// ----------------------------------------------------------------------------
// crcfr_cmd_q
// Two-entry command queue between parser and result sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crcfr_cmd_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crcfr_pkg::cmd_t din,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output crcfr_pkg::cmd_t head
);

    crcfr_pkg::cmd_t q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CHK_NEVER(a_q_overflow, clk, rst_n, push && full, "command pushed into full queue")
    `CHK_NEVER(a_q_underflow, clk, rst_n, pop && empty, "command popped from empty queue")

endmodule

// ===== src/crcfr_back.sv =====
// ----------------------------------------------------------------------------
// crcfr_back
// Result sequencer: walks each command, reads stored payload bytes and
// fills a two-entry result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crcfr_back #(
    parameter int MAX_PAYLOAD = 32,
    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  crcfr_pkg::cmd_t   cmd,
    output logic              cmd_pop,
    output logic              ram_re,
    output logic [IW:0]       ram_raddr,
    input  logic [7:0]        ram_rdata,
    input  logic              pop,
    output logic              empty,
    output crcfr_pkg::res_t   res
);

    logic [7:0]        idx_reg, idx_next;
    logic              s1_vld_reg;
    crcfr_pkg::res_t   s1_reg, s1_next;
    logic              s1_ram_reg;
    crcfr_pkg::res_t   oq_reg [2];
    crcfr_pkg::res_t   oq_in;
    logic              oq_wptr_reg, oq_rptr_reg;
    logic [1:0]        oq_cnt_reg, oq_cnt_next;
    logic [2:0]        used;
    logic              issue, is_last, deq;

    assign used      = {1'b0, oq_cnt_reg} + {2'b00, s1_vld_reg};
    assign issue     = cmd_valid && (used < 3'd2);
    assign is_last   = !cmd.use_ram || ((idx_reg + 8'd1) == cmd.length);
    assign cmd_pop   = issue && is_last;
    assign ram_re    = issue && cmd.use_ram;
    assign ram_raddr = {cmd.bank, idx_reg[IW-1:0]};
    assign idx_next  = issue ? (is_last ? 8'd0 : idx_reg + 8'd1) : idx_reg;

    assign deq   = pop && (oq_cnt_reg != 2'd0);
    assign empty = (oq_cnt_reg == 2'd0);
    assign res   = oq_reg[oq_rptr_reg];

    always_comb
    begin
        s1_next                = '0;
        s1_next.status         = cmd.status;
        s1_next.payload_length = cmd.length;
        s1_next.last           = is_last;
        oq_in                  = s1_reg;
        oq_in.payload_byte     = s1_ram_reg ? ram_rdata : 8'd0;
        oq_cnt_next            = oq_cnt_reg + 2'(s1_vld_reg) - 2'(deq);
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg     <= s1_next;
            s1_ram_reg <= cmd.use_ram;
        end
        if (s1_vld_reg)
        begin
            oq_reg[oq_wptr_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            oq_wptr_reg <= 1'b0;
            oq_rptr_reg <= 1'b0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            s1_vld_reg  <= issue;
            oq_wptr_reg <= s1_vld_reg ? ~oq_wptr_reg : oq_wptr_reg;
            oq_rptr_reg <= deq ? ~oq_rptr_reg : oq_rptr_reg;
            oq_cnt_reg  <= oq_cnt_next;
        end
    end

    `CHK_NEVER(a_oq_room, clk, rst_n, used > 3'd2, "result queue overcommitted")
    `CHK_IMPLY(a_idx_idle, clk, rst_n, !cmd_valid, idx_reg == 8'd0, "index left mid-frame without command")

endmodule
